FILE: sv/segment_intersection_2d_unit_assert.svh
// Assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_2D_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_2D_UNIT_ASSERT_SVH
`define SGI_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SGI_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`define SGI_ASSERT_RST(label, clk, rst_n, c) \
  label: assert property (@(posedge clk) !rst_n |=> (c)) \
    else $error("assertion failed");
`endif

FILE: sv/sgi_pkg.sv
// Shared widths, types and helpers for the segment intersection block
`default_nettype none
package sgi_pkg;
  localparam int CB   = 32;
  localparam int FW   = 32;
  localparam int DW   = CB + 1;
  localparam int XW   = 2 * DW + 1;
  localparam int PW   = 2 * DW;
  localparam int MW   = 3 * DW;
  localparam int QW   = CB + 3;
  localparam int RW   = 2 * DW + QW;
  localparam int QIW  = $clog2(QW);

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic [PW-1:0]        den;
    logic [RW-1:0]        rem_x;
    logic [RW-1:0]        rem_y;
    logic [QW-1:0]        q_x;
    logic [QW-1:0]        q_y;
  } cell_t;

  function automatic logic signed [DW-1:0] sx(input logic [FW-1:0] v);
    sx = {v[CB-1], v[CB-1:0]};
  endfunction

  function automatic logic [XW-1:0] absx(input logic signed [XW-1:0] v);
    absx = v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  function automatic logic in_unit(input logic signed [XW-1:0] n,
                                   input logic signed [XW-1:0] d);
    if (n == '0) in_unit = 1'b1;
    else if (n[XW-1] != d[XW-1]) in_unit = 1'b0;
    else in_unit = absx(n) <= absx(d);
  endfunction
endpackage
`default_nettype wire

FILE: sv/segment_intersection_2d_unit.sv
// Segment intersection top: front pipeline, divider cell chain, output register
// Stages: 6 front stages, 35 divider cells and 1 output register.
// Throughput: one word per cycle; the whole pipeline advances unless the
// output register holds a word that is stalled.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
`include "segment_intersection_2d_unit_assert.svh"
module segment_intersection_2d_unit import sgi_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [FW-1:0] in_first_start_x,
  input  wire logic [FW-1:0] in_first_start_y,
  input  wire logic [FW-1:0] in_first_end_x,
  input  wire logic [FW-1:0] in_first_end_y,
  input  wire logic [FW-1:0] in_second_start_x,
  input  wire logic [FW-1:0] in_second_start_y,
  input  wire logic [FW-1:0] in_second_end_x,
  input  wire logic [FW-1:0] in_second_end_y,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_hit,
  output logic [FW-1:0]      out_cross_x,
  output logic [FW-1:0]      out_cross_y
);
  logic                 adv;
  logic                 out_valid_r;
  logic                 hit_r;
  logic [FW-1:0]        cx_r, cy_r;
  cell_t                chain [QW+1];
  logic signed [CB-1:0] offx, offy, sumx, sumy;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  sgi_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
    .fsx(in_first_start_x), .fsy(in_first_start_y),
    .fex(in_first_end_x), .fey(in_first_end_y),
    .ssx(in_second_start_x), .ssy(in_second_start_y),
    .sex(in_second_end_x), .sey(in_second_end_y),
    .o(chain[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sgi_cell u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .idx(QIW'(QW - 1 - i)), .d(chain[i]), .q(chain[i+1])
    );
  end

  assign offx = chain[QW].neg_x ? CB'(-chain[QW].q_x) : CB'(chain[QW].q_x);
  assign offy = chain[QW].neg_y ? CB'(-chain[QW].q_y) : CB'(chain[QW].q_y);
  assign sumx = chain[QW].ax + offx;
  assign sumy = chain[QW].ay + offy;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= chain[QW].valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= chain[QW].hit;
      cx_r  <= chain[QW].hit ? FW'(sumx) : '0;
      cy_r  <= chain[QW].hit ? FW'(sumy) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_cross_x = cx_r;
  assign out_cross_y = cy_r;

  `SGI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid_r && !hit_r,
                  cx_r == '0 && cy_r == '0)
  `SGI_ASSERT_NXT(a_last_to_out, clk, rst_n, adv && chain[QW].valid, out_valid_r)
  `SGI_ASSERT_RST(a_reset_empty, clk, rst_n, !out_valid_r && !chain[QW].valid)
endmodule
`default_nettype wire

FILE: sv/sgi_front.sv
// Front pipeline: differences, cross products, hit test, scaled numerator
`default_nettype none
module sgi_front import sgi_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire logic [FW-1:0] fsx, fsy, fex, fey, ssx, ssy, sex, sey,
  output cell_t              o
);
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [DW-1:0] v1x_r, v1y_r, v2x_r, v2y_r, wx_r, wy_r;
  logic signed [CB-1:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r;
  logic signed [CB-1:0] ax4_r, ay4_r, ax5_r, ay5_r, ax6_r, ay6_r;
  logic signed [PW-1:0] pd0_r, pd1_r, pa0_r, pa1_r, pb0_r, pb1_r;
  logic signed [DW-1:0] v1x2_r, v1y2_r, v1x3_r, v1y3_r;
  logic signed [XW-1:0] den_r, na_r, nb_r;
  logic                 hit4_r, nx4_r, ny4_r, hit5_r, nx5_r, ny5_r, hit6_r, nx6_r, ny6_r;
  logic [XW-1:0]        nam_nxt, dm_nxt;
  logic [PW-1:0]        nam4_r, dm4_r, dm5_r, dm6_r;
  logic [DW-1:0]        mx4_r, my4_r;
  logic [PW-1:0]        xl_r, xh_r, yl_r, yh_r;
  logic [MW-1:0]        rx6_r, ry6_r;

  assign nam_nxt = absx(na_r);
  assign dm_nxt  = absx(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1x_r <= sx(fex) - sx(fsx);
      v1y_r <= sx(fey) - sx(fsy);
      v2x_r <= sx(sex) - sx(ssx);
      v2y_r <= sx(sey) - sx(ssy);
      wx_r  <= sx(fsx) - sx(ssx);
      wy_r  <= sx(fsy) - sx(ssy);
      ax1_r <= fsx[CB-1:0];
      ay1_r <= fsy[CB-1:0];

      pd0_r <= v1x_r * v2y_r;
      pd1_r <= v1y_r * v2x_r;
      pa0_r <= v2x_r * wy_r;
      pa1_r <= v2y_r * wx_r;
      pb0_r <= v1x_r * wy_r;
      pb1_r <= v1y_r * wx_r;
      v1x2_r <= v1x_r; v1y2_r <= v1y_r;
      ax2_r <= ax1_r; ay2_r <= ay1_r;

      den_r <= XW'(pd0_r) - XW'(pd1_r);
      na_r  <= XW'(pa0_r) - XW'(pa1_r);
      nb_r  <= XW'(pb0_r) - XW'(pb1_r);
      v1x3_r <= v1x2_r; v1y3_r <= v1y2_r;
      ax3_r <= ax2_r; ay3_r <= ay2_r;

      hit4_r <= (den_r != '0) && in_unit(na_r, den_r) && in_unit(nb_r, den_r);
      nam4_r <= nam_nxt[PW-1:0];
      dm4_r  <= dm_nxt[PW-1:0];
      nx4_r  <= v1x3_r[DW-1];
      ny4_r  <= v1y3_r[DW-1];
      mx4_r  <= v1x3_r[DW-1] ? DW'(-v1x3_r) : DW'(v1x3_r);
      my4_r  <= v1y3_r[DW-1] ? DW'(-v1y3_r) : DW'(v1y3_r);
      ax4_r <= ax3_r; ay4_r <= ay3_r;

      xl_r <= PW'(nam4_r[DW-1:0]) * PW'(mx4_r);
      xh_r <= PW'(nam4_r[PW-1:DW]) * PW'(mx4_r);
      yl_r <= PW'(nam4_r[DW-1:0]) * PW'(my4_r);
      yh_r <= PW'(nam4_r[PW-1:DW]) * PW'(my4_r);
      hit5_r <= hit4_r; nx5_r <= nx4_r; ny5_r <= ny4_r; dm5_r <= dm4_r;
      ax5_r <= ax4_r; ay5_r <= ay4_r;

      rx6_r <= (MW'(xh_r) << DW) + MW'(xl_r);
      ry6_r <= (MW'(yh_r) << DW) + MW'(yl_r);
      hit6_r <= hit5_r; nx6_r <= nx5_r; ny6_r <= ny5_r; dm6_r <= dm5_r;
      ax6_r <= ax5_r; ay6_r <= ay5_r;
    end
  end

  always_comb begin
    o.valid = v6_r;
    o.hit   = hit6_r;
    o.neg_x = nx6_r;
    o.neg_y = ny6_r;
    o.ax    = ax6_r;
    o.ay    = ay6_r;
    o.den   = dm6_r;
    o.rem_x = RW'(rx6_r);
    o.rem_y = RW'(ry6_r);
    o.q_x   = '0;
    o.q_y   = '0;
  end
endmodule
`default_nettype wire

FILE: sv/sgi_cell.sv
// One restoring division cell: one quotient bit for both lanes
`default_nettype none
module sgi_cell import sgi_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic [QIW-1:0] idx,
  input  wire cell_t          d,
  output cell_t               q
);
  logic [RW-1:0] dsh;
  logic          valid_r;
  cell_t         q_r;
  cell_t         q_nxt;

  assign dsh = RW'(d.den) << idx;

  always_comb begin
    q_nxt = d;
    if (dsh <= d.rem_x) begin
      q_nxt.rem_x = d.rem_x - dsh;
      q_nxt.q_x   = d.q_x | (QW'(1) << idx);
    end
    if (dsh <= d.rem_y) begin
      q_nxt.rem_y = d.rem_y - dsh;
      q_nxt.q_y   = d.q_y | (QW'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (adv) valid_r <= q_nxt.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= q_nxt;
    end
  end

  always_comb begin
    q       = q_r;
    q.valid = valid_r;
  end
endmodule
`default_nettype wire

FILE: dv/segment_intersection_2d_unit_tb.sv
// Testbench for segment_intersection_2d_unit: directed and random segment pairs checked
`timescale 1ns / 1ps
module segment_intersection_2d_unit_tb;
  import sgi_pkg::*;

  typedef struct {
    logic        hit;
    logic [31:0] x;
    logic [31:0] y;
  } meet_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [FW-1:0] in_first_start_x = '0;
  logic [FW-1:0] in_first_start_y = '0;
  logic [FW-1:0] in_first_end_x = '0;
  logic [FW-1:0] in_first_end_y = '0;
  logic [FW-1:0] in_second_start_x = '0;
  logic [FW-1:0] in_second_start_y = '0;
  logic [FW-1:0] in_second_end_x = '0;
  logic [FW-1:0] in_second_end_y = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_hit;
  logic [FW-1:0] out_cross_x;
  logic [FW-1:0] out_cross_y;

  meet_t meet_queue[$];
  int    mismatches = 0;
  int    words_sent = 0;
  int    words_seen = 0;
  int    hits_seen = 0;
  int    burst_left = 0;
  int    stall_mode = 0;
  int    stall_cycle = 0;

  segment_intersection_2d_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_start_x(in_first_start_x), .in_first_start_y(in_first_start_y),
    .in_first_end_x(in_first_end_x), .in_first_end_y(in_first_end_y),
    .in_second_start_x(in_second_start_x), .in_second_start_y(in_second_start_y),
    .in_second_end_x(in_second_end_x), .in_second_end_y(in_second_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  always #4 clk = ~clk;

  function automatic logic signed [127:0] cross2(input logic signed [127:0] ax,
      input logic signed [127:0] ay, input logic signed [127:0] bx,
      input logic signed [127:0] by);
    cross2 = ax * by - ay * bx;
  endfunction

  function automatic logic within_unit(input logic signed [127:0] n,
                                       input logic signed [127:0] d);
    logic [127:0] an, ad;
    an = n[127] ? -n : n;
    ad = d[127] ? -d : d;
    if (n == 0) within_unit = 1'b1;
    else if (n[127] != d[127]) within_unit = 1'b0;
    else within_unit = an <= ad;
  endfunction

  function automatic meet_t predict_meet(input logic [31:0] c[8]);
    logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [127:0] v1x, v1y, v2x, v2y, wx, wy, den, na, nb, px, py;
    logic [127:0] mna, mden, qx, qy, mvx, mvy;
    meet_t r;
    ax = $signed(c[0]); ay = $signed(c[1]);
    bx = $signed(c[2]); by = $signed(c[3]);
    cx = $signed(c[4]); cy = $signed(c[5]);
    dx = $signed(c[6]); dy = $signed(c[7]);
    v1x = bx - ax; v1y = by - ay;
    v2x = dx - cx; v2y = dy - cy;
    wx = ax - cx; wy = ay - cy;
    r.hit = 1'b0; r.x = '0; r.y = '0;
    den = cross2(v1x, v1y, v2x, v2y);
    na = cross2(v2x, v2y, wx, wy);
    nb = cross2(v1x, v1y, wx, wy);
    if (den != 0 && within_unit(na, den) && within_unit(nb, den)) begin
      mna = na[127] ? -na : na;
      mden = den[127] ? -den : den;
      mvx = v1x[127] ? -v1x : v1x;
      mvy = v1y[127] ? -v1y : v1y;
      qx = (mna * mvx) / mden;
      qy = (mna * mvy) / mden;
      px = v1x[127] ? ax - $signed(qx) : ax + $signed(qx);
      py = v1y[127] ? ay - $signed(qy) : ay + $signed(qy);
      r.hit = 1'b1; r.x = px[31:0]; r.y = py[31:0];
    end
    return r;
  endfunction

  task automatic send_pair(input logic [31:0] c[8]);
    logic stalled;
    in_valid <= 1'b1;
    in_first_start_x <= c[0]; in_first_start_y <= c[1];
    in_first_end_x <= c[2]; in_first_end_y <= c[3];
    in_second_start_x <= c[4]; in_second_start_y <= c[5];
    in_second_end_x <= c[6]; in_second_end_y <= c[7];
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    meet_queue.push_back(predict_meet(c));
    words_sent++;
  endtask

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (meet_queue.size() != 0) @(posedge clk);
  endtask

  task automatic send6(input logic [31:0] a, b, e, d, f, g, h, k);
    logic [31:0] c[8];
    c = '{a, b, e, d, f, g, h, k};
    send_pair(c);
  endtask

  task automatic test_extremes();
    send6(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send6(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send6(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send6(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send6(32'h80000000, 32'h0, 32'h7fffffff, 32'h0,
          32'h0, 32'h80000000, 32'h1, 32'h7fffffff);
    send6(32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff);
  endtask

  task automatic test_special_cases();
    send6(0, 0, 10, 10, 0, 10, 10, 0);
    send6(0, 0, 10, 0, 0, 1, 10, 1);
    send6(0, 0, 10, 0, 5, 0, 15, 0);
    send6(3, 3, 3, 3, 0, 0, 10, 10);
    send6(0, 0, 10, 0, 10, 0, 10, 5);
    send6(0, 0, 10, 0, 5, 0, 5, 5);
    send6(0, 0, 10, 0, 11, -5, 11, 5);
    send6(0, 0, -7, 3, -3, -2, -4, 5);
    send6(-1, -1, -8, -3, -5, 2, -2, -9);
    send6(0, 0, 7, 3, 1, 2, 4, -1);
    send6(5, 5, 5, 5, 5, 5, 5, 5);
    send6(0, 0, 10, 0, 5, 1, 5, 6);
  endtask

  function automatic logic [31:0] rand_coord(input int span);
    if (span == 0) return $urandom;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic test_random(input int count);
    logic [31:0] c[8];
    int span;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1: span = 0;
        2: span = 1 << $urandom_range(20, 30);
        default: span = $urandom_range(2, 200);
      endcase
      for (int i = 0; i < 8; i++) c[i] = rand_coord(span);
      if ($urandom_range(0, 15) == 0) c[$urandom_range(4, 7)] = c[$urandom_range(0, 3)];
      send_pair(c);
      pace_sender();
      if (n == count / 2) drain_results();
    end
  endtask

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 150 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 7) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_cycle % 5 < 3);
    endcase
  end

  always @(negedge clk) begin
    meet_t e;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (out_hit) hits_seen++;
      if (meet_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: hit=%0b x=%h y=%h",
                                       out_hit, out_cross_x, out_cross_y);
      end else begin
        e = meet_queue.pop_front();
        if (e.hit !== out_hit || e.x !== out_cross_x || e.y !== out_cross_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
                     e.hit, e.x, e.y, out_hit, out_cross_x, out_cross_y);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("segment_intersection_2d_unit test failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random(950);
    drain_results();
    repeat (60) @(posedge clk);
    if (meet_queue.size() != 0) mismatches += meet_queue.size();
    $display("sent %0d segment pairs, checked %0d words, %0d hits", words_sent,
             words_seen, hits_seen);
    $display("covered extremes, parallel, collinear, degenerate and touching cases");
    if (mismatches == 0) begin
      $display("segment_intersection_2d_unit test passed");
    end else begin
      $display("segment_intersection_2d_unit test failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+sv
sv/sgi_pkg.sv
sv/sgi_front.sv
sv/sgi_cell.sv
sv/segment_intersection_2d_unit.sv
dv/segment_intersection_2d_unit_tb.sv
